// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset
`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tpsq_pkg.sv -----
// Types and constants of the track pair share quality block
package tpsq_pkg;

	localparam int LAYER_W    = 6;
	localparam int LAYER_CMP_W = LAYER_W + 1;
	localparam int Q_W        = 16;
	localparam int QSAT_W     = Q_W + 1;
	localparam int SCORE_W    = 7;
	localparam int TOTAL_W    = 8;
	localparam int SUM_W      = 8;
	localparam int FRAC_SHIFT = 15;
	localparam int NUM_W      = 22;
	localparam int DEN_W      = 10;
	localparam int STEP_W     = $clog2(NUM_W);
	localparam int Q_ONE      = 32768;
	localparam logic [Q_W-1:0] Q_MAX = 16'h7fff;

	typedef struct packed {
		logic               take;
		logic               track;
		logic [LAYER_W-1:0] layer;
		logic               shift;
		logic               clear;
	} acc_ctl_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- rtl/core/track_pair_share_quality.sv -----
// Track pair share quality: per-layer sharing score of two tracks, divided by their hit count
// A hit word without tlast is taken and the next word may follow at once.
// The word with tlast starts a layer scan, then the divide, a state that sees it finish
// and the load of the output (an empty pair skips the divide), all with s_tready low.
// A stalled output holds the load until m_tready.
// arst_n clears the masks, counters, sequencer and output valid at once.
module track_pair_share_quality import tpsq_pkg::*; #(
	parameter int LAYER_COUNT = 55,
	parameter int MAX_TRACK_HITS = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [5:0] hit_layer, [7:6] zero
	input  logic        s_tuser,  // [0] track_index
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] quality_fixed, [22:16] score_sum, [30:23] total_hits, [31] zero
	output logic        m_tuser   // [0] empty_pair_error
);

	localparam int CNT_W  = $clog2(MAX_TRACK_HITS + 1);
	localparam int TOT_W  = CNT_W + 1;
	localparam int SCAN_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_DONE} state_t;

	state_t                   state_q;
	logic [SCAN_W-1:0]        scan_q;
	logic signed [SUM_W-1:0]  score_q, score_nxt;
	logic [TOT_W-1:0]         total_q, acc_total;
	logic                     err_q;

	acc_ctl_t                 acc_ctl;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	logic                     first_bit, second_bit;
	logic                     s_take, scan_last, out_free;
	logic [SUM_W-1:0]         mag;
	logic [QSAT_W-1:0]        qsat, qneg;
	logic [Q_W-1:0]           q_out;
	logic [SCORE_W-1:0]       score_out;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_take    = s_tvalid && s_tready;
	assign scan_last = (state_q == ST_SCAN) && (scan_q == SCAN_W'(LAYER_COUNT - 1));
	assign out_free  = !m_tvalid || m_tready;

	assign acc_ctl.take  = s_take;
	assign acc_ctl.track = s_tuser;
	assign acc_ctl.layer = s_tdata[LAYER_W-1:0];
	assign acc_ctl.shift = (state_q == ST_SCAN);
	assign acc_ctl.clear = scan_last;

	tpsq_hit_acc #(
		.LAYER_COUNT(LAYER_COUNT),
		.MAX_TRACK_HITS(MAX_TRACK_HITS)
	) u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(acc_ctl),
		.first_bit(first_bit),
		.second_bit(second_bit),
		.total(acc_total)
	);

	// shared layer: -1, one track only: +1
	always_comb begin
		if (first_bit && second_bit) score_nxt = score_q - SUM_W'(1);
		else if (first_bit ^ second_bit) score_nxt = score_q + SUM_W'(1);
		else score_nxt = score_q;
	end

	assign mag = score_nxt[SUM_W-1] ? (~score_nxt + SUM_W'(1)) : score_nxt;

	assign div_req.start = scan_last && (acc_total != '0);
	assign div_req.num   = (NUM_W'(mag) << FRAC_SHIFT) + NUM_W'(acc_total);
	assign div_req.den   = DEN_W'({acc_total, 1'b0});

	tpsq_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// clamp the magnitude to 1.0, then the positive side to the largest code
	always_comb begin
		qsat = (div_rsp.quot > NUM_W'(Q_ONE)) ? QSAT_W'(Q_ONE) : div_rsp.quot[QSAT_W-1:0];
		qneg = ~qsat + QSAT_W'(1);
		if (err_q) q_out = '0;
		else if (score_q[SUM_W-1]) q_out = qneg[Q_W-1:0];
		else if (qsat > QSAT_W'(Q_MAX)) q_out = Q_MAX;
		else q_out = qsat[Q_W-1:0];
		score_out = err_q ? '0 : score_q[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scan_q   <= '0;
			score_q  <= '0;
			total_q  <= '0;
			err_q    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// the load in ST_DONE sets valid itself
			if (m_tvalid && m_tready && state_q != ST_DONE) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_take && s_tlast) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
						score_q <= '0;
					end
				end
				ST_SCAN: begin
					score_q <= score_nxt;
					scan_q  <= scan_q + SCAN_W'(1);
					if (scan_last) begin
						total_q <= acc_total;
						err_q   <= (acc_total == '0);
						// skip the divide for an empty pair
						state_q <= (acc_total == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, TOTAL_W'(total_q), score_out, q_out};
						m_tuser  <= err_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/tpsq_hit_acc.sv -----
// Layer masks and hit counters of both tracks, with a shift-out scan path
module tpsq_hit_acc import tpsq_pkg::*; #(
	parameter int LAYER_COUNT = 55,
	parameter int MAX_TRACK_HITS = 127,
	localparam int CNT_W = $clog2(MAX_TRACK_HITS + 1),
	localparam int TOT_W = CNT_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  acc_ctl_t         ctl,
	output logic             first_bit,
	output logic             second_bit,
	output logic [TOT_W-1:0] total
);

	logic [LAYER_COUNT-1:0] mask0_q, mask1_q, hit_bit;
	logic [CNT_W-1:0]       cnt0_q, cnt1_q;
	logic                   in_range;

	assign in_range = {1'b0, ctl.layer} < LAYER_CMP_W'(LAYER_COUNT);
	assign hit_bit  = LAYER_COUNT'(1) << ctl.layer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask0_q <= '0;
			mask1_q <= '0;
			cnt0_q  <= '0;
			cnt1_q  <= '0;
		end else if (ctl.clear) begin
			mask0_q <= '0;
			mask1_q <= '0;
			cnt0_q  <= '0;
			cnt1_q  <= '0;
		end else if (ctl.shift) begin
			mask0_q <= mask0_q >> 1;
			mask1_q <= mask1_q >> 1;
		end else if (ctl.take && in_range) begin
			// hold the count once it reaches the bound
			if (ctl.track) begin
				mask1_q <= mask1_q | hit_bit;
				if (cnt1_q != CNT_W'(MAX_TRACK_HITS)) cnt1_q <= cnt1_q + CNT_W'(1);
			end else begin
				mask0_q <= mask0_q | hit_bit;
				if (cnt0_q != CNT_W'(MAX_TRACK_HITS)) cnt0_q <= cnt0_q + CNT_W'(1);
			end
		end
	end

	assign first_bit  = mask0_q[0];
	assign second_bit = mask1_q[0];
	assign total      = TOT_W'(cnt0_q) + TOT_W'(cnt1_q);

endmodule

// ----- rtl/core/tpsq_div.sv -----
// Restoring divider, one quotient bit per cycle
module tpsq_div import tpsq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W-1:0]  rem_q, den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [DEN_W:0]    part, diff;
	logic              fits;

	assign part = {rem_q, quo_q[NUM_W-1]};
	assign diff = part - {1'b0, den_q};
	assign fits = part >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// shift the quotient bit in where the numerator bit leaves
				rem_q <= fits ? diff[DEN_W-1:0] : part[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], fits};
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ----- rtl/core/tpsq_checker.sv -----
// Port-level checker of the track pair share quality block, with its bind
`include "assert_macros.svh"

module tpsq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	`AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output word dropped while stalled")
	`AST_NEXT(a_hit_ready, s_tvalid && s_tready && !s_tlast, s_tready, "not ready after a plain hit")
	`AST_NEXT(a_end_busy, s_tvalid && s_tready && s_tlast, !s_tready, "ready right after pair end")
	`AST_SAME(a_empty_zero, m_tvalid && m_tuser, m_tdata[22:0] == 23'd0, "empty pair with data")

endmodule

bind track_pair_share_quality tpsq_checker u_tpsq_checker (.*);
